// ----- rtl/hsc_pkg.sv -----
`timescale 1ns / 1ps

package hsc_pkg;

    localparam int MAX_DATA_BITS = 57;
    localparam int CODE_BITS     = 63;
    localparam int LEN_W         = 6;
    localparam int STATUS_W      = 2;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNCORRECTABLE = 2'd2;

    localparam logic [LEN_W-1:0] RESET_DATA_LENGTH = 6'd4;

    typedef struct packed {
        logic                 func;
        logic [CODE_BITS-1:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] result_word;
        logic [LEN_W-1:0]     syndrome;
        logic [STATUS_W-1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] data_mask;
        logic [CODE_BITS-1:0] code_mask;
        logic [LEN_W-1:0]     code_len;
    } cfg_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] m;
        m = raw;
        if (raw == '0)
        begin
            m = LEN_W'(1);
        end
        else if (raw > LEN_W'(MAX_DATA_BITS))
        begin
            m = LEN_W'(MAX_DATA_BITS);
        end
        return m;
    endfunction

    function automatic logic [LEN_W-1:0] code_len(input logic [LEN_W-1:0] m);
        logic [LEN_W-1:0] r;
        if (m <= LEN_W'(1))
        begin
            r = LEN_W'(2);
        end
        else if (m <= LEN_W'(4))
        begin
            r = LEN_W'(3);
        end
        else if (m <= LEN_W'(11))
        begin
            r = LEN_W'(4);
        end
        else if (m <= LEN_W'(26))
        begin
            r = LEN_W'(5);
        end
        else
        begin
            r = LEN_W'(6);
        end
        return m + r;
    endfunction

    function automatic logic [CODE_BITS-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [CODE_BITS:0] ones;
        ones = ((CODE_BITS+1)'(1) << len) - (CODE_BITS+1)'(1);
        return ones[CODE_BITS-1:0];
    endfunction

    // data bit k goes to the k-th position that is not a power of two
    function automatic logic [CODE_BITS-1:0] scatter(input logic [CODE_BITS-1:0] data);
        logic [CODE_BITS-1:0] w;
        int                   k;
        w = '0;
        k = 0;
        for (int i = 1; i <= CODE_BITS; i++)
        begin
            if ((i & (i - 1)) != 0)
            begin
                w[i-1] = data[k];
                k++;
            end
        end
        return w;
    endfunction

    function automatic logic [CODE_BITS-1:0] gather(input logic [CODE_BITS-1:0] code);
        logic [CODE_BITS-1:0] d;
        int                   k;
        d = '0;
        k = 0;
        for (int i = 1; i <= CODE_BITS; i++)
        begin
            if ((i & (i - 1)) != 0)
            begin
                d[k] = code[i-1];
                k++;
            end
        end
        return d;
    endfunction

    function automatic logic [LEN_W-1:0] syndrome(input logic [CODE_BITS-1:0] code);
        logic [LEN_W-1:0] s;
        s = '0;
        for (int i = 1; i <= CODE_BITS; i++)
        begin
            if (code[i-1])
            begin
                s = s ^ LEN_W'(i);
            end
        end
        return s;
    endfunction

endpackage

// ----- rtl/hsc_cfg.sv -----
`timescale 1ns / 1ps

module hsc_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hsc_pkg::LEN_W-1:0] cfg_data,
    output hsc_pkg::cfg_t             cfg
);

    hsc_pkg::cfg_t            cfg_reg;
    hsc_pkg::cfg_t            cfg_next;
    logic [hsc_pkg::LEN_W-1:0] m;
    logic [hsc_pkg::LEN_W-1:0] n;

    always_comb
    begin
        m                  = hsc_pkg::clamp_len(cfg_data);
        n                  = hsc_pkg::code_len(m);
        cfg_next.data_mask = hsc_pkg::low_mask(m);
        cfg_next.code_mask = hsc_pkg::low_mask(n);
        cfg_next.code_len  = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_mask <= hsc_pkg::low_mask(hsc_pkg::RESET_DATA_LENGTH);
            cfg_reg.code_mask <= hsc_pkg::low_mask(
                hsc_pkg::code_len(hsc_pkg::RESET_DATA_LENGTH));
            cfg_reg.code_len  <= hsc_pkg::code_len(hsc_pkg::RESET_DATA_LENGTH);
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/hsc_core.sv -----
`timescale 1ns / 1ps

module hsc_core (
    input  hsc_pkg::cfg_t cfg,
    input  hsc_pkg::cmd_t cmd,
    output hsc_pkg::rsp_t rsp
);

    logic [hsc_pkg::CODE_BITS-1:0] enc_word;
    logic [hsc_pkg::LEN_W-1:0]     enc_acc;
    logic [hsc_pkg::CODE_BITS-1:0] dec_code;
    logic [hsc_pkg::LEN_W-1:0]     dec_synd;
    logic [hsc_pkg::CODE_BITS-1:0] flip;
    logic                          fixable;

    always_comb
    begin
        enc_word = hsc_pkg::scatter(cmd.payload & cfg.data_mask);
        enc_acc  = hsc_pkg::syndrome(enc_word);
        for (int j = 0; j < hsc_pkg::LEN_W; j++)
        begin
            enc_word[(1 << j) - 1] = enc_acc[j];
        end
    end

    always_comb
    begin
        dec_code = cmd.payload & cfg.code_mask;
        dec_synd = hsc_pkg::syndrome(dec_code);
        fixable  = (dec_synd != '0) && (dec_synd <= cfg.code_len);
        for (int i = 1; i <= hsc_pkg::CODE_BITS; i++)
        begin
            flip[i-1] = fixable && (dec_synd == hsc_pkg::LEN_W'(i));
        end
    end

    always_comb
    begin
        if (cmd.func == hsc_pkg::FUNC_DECODE)
        begin
            rsp.result_word = hsc_pkg::gather(dec_code ^ flip);
            rsp.syndrome    = dec_synd;
            if (dec_synd == '0)
            begin
                rsp.status = hsc_pkg::STATUS_OK;
            end
            else if (fixable)
            begin
                rsp.status = hsc_pkg::STATUS_CORRECTED;
            end
            else
            begin
                rsp.status = hsc_pkg::STATUS_UNCORRECTABLE;
            end
        end
        else
        begin
            rsp.result_word = enc_word;
            rsp.syndrome    = '0;
            rsp.status      = hsc_pkg::STATUS_OK;
        end
    end

endmodule

// ----- rtl/hamming_sec_codec_unit.sv -----
`timescale 1ns / 1ps
// Hamming single-error-correcting encoder/decoder, even parity.
// cmd channel (cmd_valid/cmd_stall/cmd): one word per handshake; func selects
// encode (payload = data bits) or decode (payload = codeword, position i at
// bit i-1). rsp channel (rsp_valid/rsp_stall/rsp): one result word per cmd
// word, in order: codeword or corrected data, syndrome and status.
// cfg_we/cfg_data write the data length m (0 reads as 1, above 57 as 57);
// write it only while no word is in flight.
// A cmd word is taken into the input register, then passes through the XOR
// trees into the result register, which drives rsp_valid. Throughput: one
// word per cycle while rsp_stall is low, set by the single-pass syndrome
// tree between the two registers.
// A stalled rsp word holds; cmd_stall rises only when both registers are
// full, so one word can be taken while a finished result waits.
// Reset empties both registers and sets m to 4 (n = 7).
module hamming_sec_codec_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [hsc_pkg::LEN_W-1:0] cfg_data,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  hsc_pkg::cmd_t             cmd,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output hsc_pkg::rsp_t             rsp
);

    hsc_pkg::cfg_t cfg;
    hsc_pkg::cmd_t cmd_reg;
    logic          cmd_valid_reg;
    hsc_pkg::rsp_t rsp_next;
    hsc_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;
    logic          adv_rsp;
    logic          adv_cmd;

    hsc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    hsc_core u_core (
        .cfg (cfg),
        .cmd (cmd_reg),
        .rsp (rsp_next)
    );

    assign adv_rsp   = !rsp_valid_reg || !rsp_stall;
    assign adv_cmd   = !cmd_valid_reg || adv_rsp;
    assign cmd_stall = !adv_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_cmd)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (adv_rsp)
            begin
                rsp_valid_reg <= cmd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_cmd && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (adv_rsp && cmd_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_valid_reg)
        else $error("accepted word not held in input register");

    a_ok_zero_synd: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == hsc_pkg::STATUS_OK) |-> (rsp.syndrome == '0))
        else $error("clean status with nonzero syndrome");

    a_corr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == hsc_pkg::STATUS_CORRECTED)
        |-> (rsp.syndrome != '0 && rsp.syndrome <= cfg.code_len))
        else $error("corrected position outside codeword");

    a_uncorr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == hsc_pkg::STATUS_UNCORRECTABLE)
        |-> (rsp.syndrome > cfg.code_len))
        else $error("uncorrectable flagged for in-range syndrome");

endmodule
